/* sv/gco_pkg.sv */
// Shared types, codes and constants for the grid cell odometer.
`timescale 1ns / 1ps
package gco_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_CELL_COUNTS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_START    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_END      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BARRIER_FIX   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK_DIVIDE   = 3'd4;

    localparam logic [23:0] RST_CELL_COUNTS = 24'd46179;
    localparam logic [23:0] RST_SCAN_START  = 24'd23089;
    localparam logic [23:0] RST_SCAN_END    = 24'd34634;
    localparam logic [23:0] RST_BARRIER_FIX = 24'd36943;
    localparam logic [15:0] RST_TICK_DIVIDE = 16'd10;

    localparam logic [1:0] HEADING_EAST  = 2'd0;
    localparam logic [1:0] HEADING_NORTH = 2'd1;
    localparam logic [1:0] HEADING_WEST  = 2'd2;
    localparam logic [1:0] HEADING_SOUTH = 2'd3;

    localparam logic signed [31:0] ACC_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ACC_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_TURN    = 3'd1,
        MODE_ADVANCE = 3'd2,
        MODE_SET_ACC = 3'd3,
        MODE_READ    = 3'd4
    } mode_t;

    typedef struct packed {
        logic [23:0] cell_counts;
        logic [23:0] scan_start_counts;
        logic [23:0] scan_end_counts;
        logic [23:0] barrier_fix_counts;
        logic [15:0] tick_divide;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] left_count;
        logic signed [15:0] right_count;
        logic               straight;
        logic               barrier_seen;
        logic signed [2:0]  turn_quarters;
        logic [7:0]         cells;
        logic signed [31:0] acc_value;
    } item_t;

    typedef struct packed {
        logic [3:0]         cell_x;
        logic [3:0]         cell_y;
        logic [1:0]         dir_quadrant;
        logic signed [31:0] count_sum;
        logic               scan_done;
        logic               moved_flag;
        logic [15:0]        tick_count;
    } state_t;

    typedef struct packed {
        logic [3:0]         pos_x;
        logic [3:0]         pos_y;
        logic [1:0]         heading;
        logic signed [31:0] accumulator;
        logic               cell_step;
        logic               barrier_step;
        logic               scan_trigger;
        logic               update_flag;
        logic               fatal_reset;
    } result_t;

    localparam state_t STATE_RESET = '{
        cell_x:       4'd0,
        cell_y:       4'd0,
        dir_quadrant: HEADING_NORTH,
        count_sum:    32'sd0,
        scan_done:    1'b0,
        moved_flag:   1'b0,
        tick_count:   16'd0
    };

endpackage

/* sv/gco_cfg.sv */
// Configuration register file of the grid cell odometer.
`timescale 1ns / 1ps
module gco_cfg
    import gco_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CELL_COUNTS: cfg_next.cell_counts        = cfg_data;
                REG_SCAN_START:  cfg_next.scan_start_counts  = cfg_data;
                REG_SCAN_END:    cfg_next.scan_end_counts    = cfg_data;
                REG_BARRIER_FIX: cfg_next.barrier_fix_counts = cfg_data;
                REG_TICK_DIVIDE: cfg_next.tick_divide        = cfg_data[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_counts        <= RST_CELL_COUNTS;
            cfg_reg.scan_start_counts  <= RST_SCAN_START;
            cfg_reg.scan_end_counts    <= RST_SCAN_END;
            cfg_reg.barrier_fix_counts <= RST_BARRIER_FIX;
            cfg_reg.tick_divide        <= RST_TICK_DIVIDE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/gco_step.sv */
// Single-pass update logic: next odometer state and result for one item.
`timescale 1ns / 1ps
module gco_step
    import gco_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  cur,
    input  item_t   item,
    output state_t  nxt,
    output result_t res
);

    logic [15:0]        tick_inc;
    logic               tick_fire;
    logic signed [33:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic signed [32:0] sum_ext;
    logic               in_window;
    logic               reach_cell;
    logic               barrier_hit;
    logic               cstep;
    logic               bstep;
    logic               scan;
    logic               move_en;
    logic [7:0]         move_n;
    logic signed [9:0]  delta_x;
    logic signed [9:0]  delta_y;
    logic signed [9:0]  new_x;
    logic signed [9:0]  new_y;
    logic               left_maze;
    logic               fatal;
    logic               flag_out;
    state_t             work;

    assign tick_inc  = cur.tick_count + 16'd1;
    assign tick_fire = (tick_inc >= cfg.tick_divide);

    assign sum_wide = {{2{cur.count_sum[31]}}, cur.count_sum}
                    + {{18{item.left_count[15]}}, item.left_count}
                    + {{18{item.right_count[15]}}, item.right_count};

    always_comb
    begin
        if (sum_wide[33:31] == 3'b000 || sum_wide[33:31] == 3'b111)
            sum_sat = sum_wide[31:0];
        else if (sum_wide[33])
            sum_sat = ACC_MIN;
        else
            sum_sat = ACC_MAX;
    end

    assign sum_ext   = {sum_sat[31], sum_sat};
    assign in_window = (sum_ext >= $signed({9'd0, cfg.scan_start_counts}))
                    && (sum_ext <= $signed({9'd0, cfg.scan_end_counts}));
    assign reach_cell  = (sum_ext >= $signed({9'd0, cfg.cell_counts}));
    assign barrier_hit = (sum_ext > $signed({9'd0, cfg.barrier_fix_counts}));

    always_comb
    begin
        case (cur.dir_quadrant)
            HEADING_EAST:
            begin
                delta_x = $signed({2'b00, move_n});
                delta_y = 10'sd0;
            end
            HEADING_NORTH:
            begin
                delta_x = 10'sd0;
                delta_y = $signed({2'b00, move_n});
            end
            HEADING_WEST:
            begin
                delta_x = -$signed({2'b00, move_n});
                delta_y = 10'sd0;
            end
            default:
            begin
                delta_x = 10'sd0;
                delta_y = -$signed({2'b00, move_n});
            end
        endcase
    end

    assign new_x     = $signed({6'd0, cur.cell_x}) + delta_x;
    assign new_y     = $signed({6'd0, cur.cell_y}) + delta_y;
    assign left_maze = (new_x[9:4] != 6'd0) || (new_y[9:4] != 6'd0);

    always_comb
    begin
        work    = cur;
        cstep   = 1'b0;
        bstep   = 1'b0;
        scan    = 1'b0;
        move_en = 1'b0;
        move_n  = 8'd1;
        unique case (item.mode)
            MODE_TICK:
            begin
                work.tick_count = tick_fire ? 16'd0 : tick_inc;
                if (tick_fire)
                begin
                    if (item.straight)
                    begin
                        work.count_sum = sum_sat;
                        if (!cur.scan_done && in_window)
                        begin
                            scan           = 1'b1;
                            work.scan_done = 1'b1;
                        end
                        if (reach_cell)
                        begin
                            work.count_sum = sum_sat - $signed({8'd0, cfg.cell_counts});
                            cstep          = 1'b1;
                        end
                        else if (item.barrier_seen && barrier_hit)
                        begin
                            work.count_sum = 32'sd0;
                            bstep          = 1'b1;
                        end
                        if (cstep || bstep)
                        begin
                            work.moved_flag = 1'b1;
                            work.scan_done  = 1'b0;
                            move_en         = 1'b1;
                        end
                    end
                    else
                    begin
                        work.count_sum = 32'sd0;
                    end
                end
            end
            MODE_TURN:
                work.dir_quadrant = cur.dir_quadrant + item.turn_quarters[1:0];
            MODE_ADVANCE:
            begin
                move_n  = item.cells;
                move_en = 1'b1;
            end
            MODE_SET_ACC:
                work.count_sum = item.acc_value;
            default:
                work = cur;
        endcase
    end

    assign fatal = move_en && left_maze;

    always_comb
    begin
        nxt      = work;
        flag_out = work.moved_flag;
        if (move_en && !left_maze)
        begin
            nxt.cell_x = new_x[3:0];
            nxt.cell_y = new_y[3:0];
        end
        if (item.mode == MODE_READ)
            nxt.moved_flag = 1'b0;
        if (fatal)
        begin
            nxt      = STATE_RESET;
            flag_out = 1'b0;
        end
    end

    assign res.pos_x        = fatal ? STATE_RESET.cell_x : nxt.cell_x;
    assign res.pos_y        = fatal ? STATE_RESET.cell_y : nxt.cell_y;
    assign res.heading      = nxt.dir_quadrant;
    assign res.accumulator  = nxt.count_sum;
    assign res.cell_step    = cstep;
    assign res.barrier_step = bstep;
    assign res.scan_trigger = scan;
    assign res.update_flag  = flag_out;
    assign res.fatal_reset  = fatal;

endmodule

/* sv/grid_cell_odometer_top.sv */
// Top level of the grid cell odometer: item register, update logic, result register.
`timescale 1ns / 1ps
// Cell odometer for a maze robot. Each item is taken into an input register,
// the cell position, heading and count accumulator are updated by
// combinational logic, and the result lands in an output register: one item
// per clock unless results stall. An item passes the input register, then
// the output register. The input register is freed whenever the result
// register is empty or being read; while a result waits, one more item can
// be taken and is held until the result is read. Configuration writes take
// effect on the next clock and are meant for idle periods.
module grid_cell_odometer_top
    import gco_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [2:0]             mode,
    input  logic signed [15:0]     left_count,
    input  logic signed [15:0]     right_count,
    input  logic                   straight,
    input  logic                   barrier_seen,
    input  logic signed [2:0]      turn_quarters,
    input  logic [7:0]             cells,
    input  logic signed [31:0]     acc_value,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [3:0]             pos_x,
    output logic [3:0]             pos_y,
    output logic [1:0]             heading,
    output logic signed [31:0]     accumulator,
    output logic                   cell_step,
    output logic                   barrier_step,
    output logic                   scan_trigger,
    output logic                   update_flag,
    output logic                   fatal_reset,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_full_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;
    logic    fire;
    logic    take;

    gco_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gco_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    assign advance    = !result_valid_reg || result_ready;
    assign fire       = item_full_reg && advance;
    assign item_ready = !item_full_reg || advance;
    assign take       = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= STATE_RESET;
        end
        else
        begin
            if (take)
                item_full_reg <= 1'b1;
            else if (fire)
                item_full_reg <= 1'b0;
            if (fire)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if (fire)
                state_reg <= state_next;
        end
    end

    // hold payload until the next transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.mode          <= mode;
            item_reg.left_count    <= left_count;
            item_reg.right_count   <= right_count;
            item_reg.straight      <= straight;
            item_reg.barrier_seen  <= barrier_seen;
            item_reg.turn_quarters <= turn_quarters;
            item_reg.cells         <= cells;
            item_reg.acc_value     <= acc_value;
        end
        if (fire)
            result_reg <= step_res;
    end

    assign result_valid = result_valid_reg;
    assign pos_x        = result_reg.pos_x;
    assign pos_y        = result_reg.pos_y;
    assign heading      = result_reg.heading;
    assign accumulator  = result_reg.accumulator;
    assign cell_step    = result_reg.cell_step;
    assign barrier_step = result_reg.barrier_step;
    assign scan_trigger = result_reg.scan_trigger;
    assign update_flag  = result_reg.update_flag;
    assign fatal_reset  = result_reg.fatal_reset;

endmodule

/* sv/gco_checker.sv */
// Port-level assertions for the grid cell odometer, bound to the top level.
`timescale 1ns / 1ps
module gco_checker
    import gco_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input logic [3:0]         pos_x,
    input logic [3:0]         pos_y,
    input logic [1:0]         heading,
    input logic signed [31:0] accumulator,
    input logic               cell_step,
    input logic               barrier_step,
    input logic               update_flag,
    input logic               fatal_reset
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(accumulator)
            && $stable(pos_x) && $stable(pos_y))
        else $error("stalled result changed");

    a_one_step_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(cell_step && barrier_step))
        else $error("cell and barrier step together");

    a_fatal_shows_reset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && fatal_reset |-> pos_x == 4'd0 && pos_y == 4'd0
            && heading == HEADING_NORTH && accumulator == 32'sd0 && !update_flag)
        else $error("fatal result does not show reset state");

    a_cell_step_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && cell_step |-> !accumulator[31])
        else $error("negative accumulator after cell step");

endmodule

bind grid_cell_odometer_top gco_checker u_gco_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .heading      (heading),
    .accumulator  (accumulator),
    .cell_step    (cell_step),
    .barrier_step (barrier_step),
    .update_flag  (update_flag),
    .fatal_reset  (fatal_reset)
);

/* tb/testbench.sv */
// Testbench for the grid cell odometer: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module testbench;
    import gco_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_LIMIT = 100;
    localparam int SETTINGS_N  = 8;
    localparam int MAZE_MAX    = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   item_valid    = 1'b0;
    logic                   item_ready;
    logic [2:0]             mode          = '0;
    logic signed [15:0]     left_count    = '0;
    logic signed [15:0]     right_count   = '0;
    logic                   straight      = 1'b0;
    logic                   barrier_seen  = 1'b0;
    logic signed [2:0]      turn_quarters = '0;
    logic [7:0]             cells         = '0;
    logic signed [31:0]     acc_value     = '0;
    logic                   result_valid;
    logic                   result_ready  = 1'b0;
    logic [3:0]             pos_x;
    logic [3:0]             pos_y;
    logic [1:0]             heading;
    logic signed [31:0]     accumulator;
    logic                   cell_step;
    logic                   barrier_step;
    logic                   scan_trigger;
    logic                   update_flag;
    logic                   fatal_reset;
    logic                   cfg_write     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    cfg_t    odo_cfg;
    state_t  odo_state;
    item_t   pending_items[$];
    result_t expected_odometry[$];
    item_t   on_bus;
    result_t predicted_now;
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_gap    = 0;
    int      send_calm   = 0;
    int      recv_stall  = 0;
    int      recv_calm   = 0;

    grid_cell_odometer_top DUT (.*);

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic check_result(input result_t want);
        check_field("pos_x", pos_x, want.pos_x);
        check_field("pos_y", pos_y, want.pos_y);
        check_field("heading", heading, want.heading);
        check_field("accumulator", $signed(accumulator), $signed(want.accumulator));
        check_field("cell_step", cell_step, want.cell_step);
        check_field("barrier_step", barrier_step, want.barrier_step);
        check_field("scan_trigger", scan_trigger, want.scan_trigger);
        check_field("update_flag", update_flag, want.update_flag);
        check_field("fatal_reset", fatal_reset, want.fatal_reset);
    endtask

    task automatic move_cells(input int n, output logic left_maze);
        int nx;
        int ny;
        nx = odo_state.cell_x;
        ny = odo_state.cell_y;
        case (odo_state.dir_quadrant)
            HEADING_EAST:  nx = nx + n;
            HEADING_NORTH: ny = ny + n;
            HEADING_WEST:  nx = nx - n;
            default:       ny = ny - n;
        endcase
        left_maze = (nx < 0 || nx > MAZE_MAX || ny < 0 || ny > MAZE_MAX);
        if (!left_maze)
        begin
            odo_state.cell_x = nx[3:0];
            odo_state.cell_y = ny[3:0];
        end
    endtask

    task automatic odometer_step(input item_t it, output result_t res);
        longint sum;
        logic   cstep;
        logic   bstep;
        logic   scan;
        logic   fatal;
        logic   flag_out;
        cstep = 1'b0;
        bstep = 1'b0;
        scan  = 1'b0;
        fatal = 1'b0;
        case (it.mode)
            MODE_TICK:
            begin
                odo_state.tick_count = odo_state.tick_count + 16'd1;
                if (odo_state.tick_count >= odo_cfg.tick_divide)
                begin
                    odo_state.tick_count = '0;
                    if (it.straight)
                    begin
                        sum = longint'($signed(odo_state.count_sum))
                            + longint'($signed(it.left_count))
                            + longint'($signed(it.right_count));
                        if (sum > longint'(ACC_MAX))
                            sum = longint'(ACC_MAX);
                        if (sum < longint'(ACC_MIN))
                            sum = longint'(ACC_MIN);
                        odo_state.count_sum = sum[31:0];
                        if (!odo_state.scan_done
                            && sum >= longint'(odo_cfg.scan_start_counts)
                            && sum <= longint'(odo_cfg.scan_end_counts))
                        begin
                            scan = 1'b1;
                            odo_state.scan_done = 1'b1;
                        end
                        if (sum >= longint'(odo_cfg.cell_counts))
                        begin
                            sum = sum - longint'(odo_cfg.cell_counts);
                            odo_state.count_sum = sum[31:0];
                            cstep = 1'b1;
                        end
                        else if (it.barrier_seen && sum > longint'(odo_cfg.barrier_fix_counts))
                        begin
                            odo_state.count_sum = '0;
                            bstep = 1'b1;
                        end
                        if (cstep || bstep)
                        begin
                            odo_state.moved_flag = 1'b1;
                            odo_state.scan_done = 1'b0;
                            move_cells(1, fatal);
                        end
                    end
                    else
                        odo_state.count_sum = '0;
                end
            end
            MODE_TURN:
                odo_state.dir_quadrant = odo_state.dir_quadrant + it.turn_quarters[1:0];
            MODE_ADVANCE:
                move_cells(int'(it.cells), fatal);
            MODE_SET_ACC:
                odo_state.count_sum = it.acc_value;
            default:
                ;
        endcase
        flag_out = odo_state.moved_flag;
        if (it.mode == MODE_READ)
            odo_state.moved_flag = 1'b0;
        if (fatal)
        begin
            odo_state = STATE_RESET;
            flag_out = 1'b0;
        end
        res.pos_x        = odo_state.cell_x;
        res.pos_y        = odo_state.cell_y;
        res.heading      = odo_state.dir_quadrant;
        res.accumulator  = odo_state.count_sum;
        res.cell_step    = cstep;
        res.barrier_step = bstep;
        res.scan_trigger = scan;
        res.update_flag  = flag_out;
        res.fatal_reset  = fatal;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // drive items
    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && item_ready)
            begin
                odometer_step(on_bus, predicted_now);
                expected_odometry.push_back(predicted_now);
            end
            if (!item_valid || item_ready)
            begin
                if (send_gap > 0 || pending_items.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    item_valid <= 1'b0;
                end
                else
                begin
                    on_bus = pending_items.pop_front();
                    mode          <= on_bus.mode;
                    left_count    <= on_bus.left_count;
                    right_count   <= on_bus.right_count;
                    straight      <= on_bus.straight;
                    barrier_seen  <= on_bus.barrier_seen;
                    turn_quarters <= on_bus.turn_quarters;
                    cells         <= on_bus.cells;
                    acc_value     <= on_bus.acc_value;
                    item_valid    <= 1'b1;
                    if (send_calm > 0)
                        send_calm--;
                    else if ($urandom_range(0, 2) == 0)
                        send_gap = pick_gap();
                    if ($urandom_range(0, 199) == 0)
                        send_calm = $urandom_range(30, 150);
                end
            end
        end
    end

    // check results, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_odometry.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                    check_result(expected_odometry.pop_front());
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (recv_calm > 0)
                    recv_calm--;
                else if ($urandom_range(0, 3) == 0)
                    recv_stall = pick_gap();
                if ($urandom_range(0, 199) == 0)
                    recv_calm = $urandom_range(30, 150);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic queue_item(input logic [2:0] m, input logic signed [15:0] lc,
                              input logic signed [15:0] rc, input logic st, input logic bs,
                              input logic signed [2:0] tq, input logic [7:0] n,
                              input logic signed [31:0] acc);
        item_t it;
        it.mode          = m;
        it.left_count    = lc;
        it.right_count   = rc;
        it.straight      = st;
        it.barrier_seen  = bs;
        it.turn_quarters = tq;
        it.cells         = n;
        it.acc_value     = acc;
        pending_items.push_back(it);
    endtask

    function automatic logic signed [31:0] acc_target();
        case ($urandom_range(0, 11))
            0:       return 32'(odo_cfg.cell_counts) - 1;
            1:       return 32'(odo_cfg.cell_counts);
            2:       return 32'(odo_cfg.scan_start_counts) - 1;
            3:       return 32'(odo_cfg.scan_start_counts);
            4:       return 32'(odo_cfg.scan_end_counts);
            5:       return 32'(odo_cfg.scan_end_counts) + 1;
            6:       return 32'(odo_cfg.barrier_fix_counts);
            7:       return 32'(odo_cfg.barrier_fix_counts) + 1;
            8:       return ACC_MAX - $urandom_range(0, 40000);
            9:       return ACC_MIN + $urandom_range(0, 40000);
            10:      return $urandom;
            default: return $urandom_range(0, 2 * int'(odo_cfg.cell_counts));
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    roll;
        int    mag;
        it.mode          = MODE_TICK;
        it.left_count    = 16'($urandom);
        it.right_count   = 16'($urandom);
        it.straight      = 1'($urandom);
        it.barrier_seen  = 1'($urandom);
        it.turn_quarters = 3'($urandom);
        it.cells         = 8'($urandom);
        it.acc_value     = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            mag = int'(odo_cfg.cell_counts) / (2 * $urandom_range(1, 8));
            if (mag > 32767)
                mag = 32767;
            it.left_count   = 16'($urandom_range(0, mag));
            it.right_count  = 16'($urandom_range(0, mag));
            it.straight     = ($urandom_range(0, 9) != 0);
            it.barrier_seen = ($urandom_range(0, 5) == 0);
        end
        else if (roll < 63)
            it.mode = MODE_TICK;
        else if (roll < 71)
        begin
            it.mode = MODE_TURN;
            if ($urandom_range(0, 19) == 0)
                it.turn_quarters = 3'b100;
            else
                it.turn_quarters = 3'($urandom_range(0, 6) - 3);
        end
        else if (roll < 77)
        begin
            it.mode = MODE_ADVANCE;
            if ($urandom_range(0, 3) != 0)
                it.cells = 8'($urandom_range(0, 4));
        end
        else if (roll < 86)
        begin
            it.mode = MODE_SET_ACC;
            it.acc_value = acc_target();
        end
        else if (roll < 96)
            it.mode = MODE_READ;
        else
            it.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        return it;
    endfunction

    task automatic queue_random(input int n);
        repeat (n)
            pending_items.push_back(random_item());
    endtask

    // sample on the falling edge so the driver and monitor have settled
    task automatic wait_idle();
        while (pending_items.size() != 0 || item_valid || expected_odometry.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_registers(input cfg_t setting);
        write_reg(REG_CELL_COUNTS, setting.cell_counts);
        write_reg(REG_SCAN_START, setting.scan_start_counts);
        write_reg(REG_SCAN_END, setting.scan_end_counts);
        write_reg(REG_BARRIER_FIX, setting.barrier_fix_counts);
        write_reg(REG_TICK_DIVIDE, {8'($urandom), setting.tick_divide});
        write_reg(REG_UNUSED, 24'($urandom));
        cfg_write <= 1'b0;
        @(posedge clk);
        odo_cfg = setting;
    endtask

    function automatic cfg_t phase_setting(input int p);
        cfg_t s;
        case (p)
            0:  s = {24'd46179, 24'd23089, 24'd34634, 24'd36943, 16'd1};
            1:  s = {24'd1000, 24'd300, 24'd700, 24'd500, 16'd2};
            2:  s = {24'd0, 24'd0, 24'd0, 24'd0, 16'd0};
            3:  s = {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF};
            4:  s = {24'hFFFFFF, 24'd16000000, 24'hFFFFFF, 24'd16700000, 16'd1};
            6:  s = {24'd1, 24'd0, 24'hFFFFFF, 24'd0, 16'd1};
            7:  s = {24'd5000, 24'd5000, 24'd4999, 24'd4000, 16'd3};
            default:
            begin
                s.cell_counts        = 24'($urandom_range(1, 200000));
                s.scan_start_counts  = 24'($urandom_range(0, 200000));
                s.scan_end_counts    = 24'($urandom_range(0, 200000));
                s.barrier_fix_counts = 24'($urandom_range(0, 200000));
                s.tick_divide        = 16'($urandom_range(0, 6));
            end
        endcase
        return s;
    endfunction

    initial
    begin
        odo_cfg   = {RST_CELL_COUNTS, RST_SCAN_START, RST_SCAN_END, RST_BARRIER_FIX,
                     RST_TICK_DIVIDE};
        odo_state = STATE_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0);
        queue_item(MODE_TURN, 0, 0, 0, 0, 1, 0, 0);
        queue_item(MODE_TURN, 0, 0, 0, 0, -3, 0, 0);
        queue_item(MODE_TURN, 0, 0, 0, 0, 2, 0, 0);
        queue_item(MODE_SPARE_FIRST, 0, 0, 0, 0, 0, 0, 0);
        queue_item(MODE_SPARE_LAST, -1, -1, 1, 1, -1, 8'hFF, -1);
        queue_item(MODE_ADVANCE, 0, 0, 0, 0, 0, 0, 0);
        queue_item(MODE_ADVANCE, 0, 0, 0, 0, 0, 15, 0);
        queue_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0);
        queue_item(MODE_ADVANCE, 0, 0, 0, 0, 0, 1, 0);
        queue_item(MODE_SET_ACC, 0, 0, 0, 0, 0, 0, ACC_MAX);
        repeat (9)
            queue_item(MODE_TICK, 16'sh7FFF, 16'sh7FFF, 1, 0, 0, 0, 0);
        queue_item(MODE_TICK, 16'sh7FFF, 16'sh7FFF, 1, 1, 0, 0, 0);
        queue_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0);
        queue_item(MODE_SET_ACC, 0, 0, 0, 0, 0, 0, ACC_MIN);
        queue_item(MODE_TURN, 0, 0, 0, 0, -1, 0, 0);
        queue_item(MODE_ADVANCE, 0, 0, 0, 0, 0, 8'hFF, 0);
        wait_idle();

        queue_random(250);
        wait_idle();

        for (int p = 0; p < SETTINGS_N; p++)
        begin
            program_registers(phase_setting(p));
            queue_random(p == 3 ? 60 : 210);
            wait_idle();
        end

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* grid_cell_odometer_top.f */
sv/gco_pkg.sv
sv/gco_cfg.sv
sv/gco_step.sv
sv/grid_cell_odometer_top.sv
sv/gco_checker.sv
tb/testbench.sv
